// ----- hw/rtl/rast_pkg.sv -----
// Shared types and constants for the range assign and range sum store.
package rast_pkg;

    localparam int unsigned IDX_W = 11;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned SUM_W = 42;
    localparam logic [IDX_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic CMD_ASSIGN = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic load;
        logic clear_en;
        logic write_en;
        logic read_en;
        logic finish;
    } rast_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic cursor_last;
        logic is_query;
        logic invalid;
        logic out_busy;
    } rast_stat_t;

endpackage

// ----- hw/rtl/rast_ctrl.sv -----
// Sequencing state machine for the range assign and range sum store.
module rast_ctrl
    import rast_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cfg_we,
    input  rast_stat_t stat,
    output rast_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_DISPATCH = 7'b0000100,
        ST_WRITE    = 7'b0001000,
        ST_READ     = 7'b0010000,
        ST_DRAIN    = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } rast_state_t;

    rast_state_t state_reg;
    rast_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (stat.invalid)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.is_query)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_en = 1'b1;
                if (stat.cursor_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                cmd.read_en = 1'b1;
                if (stat.cursor_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
    end

endmodule

// ----- hw/rtl/rast_dp.sv -----
// Element store, range cursor, accumulator and result register.
module rast_dp
    import rast_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rast_cmd_t               cmd,
    output rast_stat_t              stat,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_wdata,
    input  logic                    command,
    input  logic [IDX_W-1:0]        range_low,
    input  logic [IDX_W-1:0]        range_high,
    input  logic signed [VAL_W-1:0] assign_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [SUM_W-1:0] range_sum,
    output logic                    status
);

    localparam int unsigned AW = $clog2(MAX_ELEMENTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);

    logic signed [VAL_W-1:0] mem [MAX_ELEMENTS];

    logic [IDX_W-1:0]        count_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic [IDX_W-1:0]        cursor_reg;
    logic [IDX_W-1:0]        high_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    query_reg;
    logic                    invalid_reg;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    rd_vld_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    status_reg;
    logic [AW-1:0]           addr;
    logic                    range_bad;
    logic [IDX_W-1:0]        cursor_minus1;

    assign cursor_minus1 = cursor_reg - IDX_W'(1);
    assign addr = AW'(cursor_minus1);

    assign range_bad = (range_low == '0) || (range_low > range_high) ||
                       (range_high > count_reg) || (32'(range_high) > MAX_ELEMENTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            clr_addr_reg <= '0;
            rd_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
                clr_addr_reg <= '0;
            end
            else if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            rd_vld_reg <= cmd.read_en;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.write_en)
        begin
            mem[addr] <= value_reg;
        end
        if (cmd.read_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cursor_reg <= range_low;
            high_reg <= range_high;
            value_reg <= assign_value;
            query_reg <= (command == CMD_QUERY);
            invalid_reg <= range_bad;
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.write_en || cmd.read_en)
            begin
                cursor_reg <= cursor_reg + IDX_W'(1);
            end
            if (rd_vld_reg)
            begin
                acc_reg <= acc_reg + SUM_W'(rd_data_reg);
            end
        end
        if (cmd.finish)
        begin
            sum_reg <= (query_reg && !invalid_reg) ? acc_reg : '0;
            status_reg <= invalid_reg ? STATUS_INVALID : STATUS_DONE;
        end
    end

    assign stat.clear_done = (clr_addr_reg == LAST_ADDR);
    assign stat.cursor_last = (cursor_reg == high_reg);
    assign stat.is_query = query_reg;
    assign stat.invalid = invalid_reg;
    assign stat.out_busy = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign range_sum = sum_reg;
    assign status = status_reg;

    a_no_write_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_en && cmd.read_en))
        else $error("Store written and read in the same cycle.");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && out_stall))
        else $error("Result overwritten before its transfer.");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_en || cmd.read_en) |-> (cursor_reg != '0 && cursor_reg <= high_reg))
        else $error("Cursor outside the requested range.");

endmodule

// ----- hw/rtl/range_assign_range_sum_tree.sv -----
// Top level of the range assign and range sum store.
// Each transfer is either an assign, which writes one value to every element of the range,
// or a query, which returns the signed sum of the range; each gives exactly one result.
// An assign walks the range in the write state, a query in the read state and then a drain
// state; the single port of the element memory handles one element per cycle;
// an invalid range goes from dispatch straight to finish. After reset and after every write
// of element_count the store is cleared element by element, during which no item is taken.
module range_assign_range_sum_tree
    import rast_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    command,
    input  logic [IDX_W-1:0]        range_low,
    input  logic [IDX_W-1:0]        range_high,
    input  logic signed [VAL_W-1:0] assign_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [SUM_W-1:0] range_sum,
    output logic                    status
);

    rast_cmd_t  cmd;
    rast_stat_t stat;

    rast_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cfg_we   (cfg_we),
        .stat     (stat),
        .cmd      (cmd)
    );

    rast_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .command      (command),
        .range_low    (range_low),
        .range_high   (range_high),
        .assign_value (assign_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .range_sum    (range_sum),
        .status       (status)
    );

endmodule
